// ===== hw/rtl/fls_pkg.sv =====
// fls_pkg: shared types and codes for the free list slab allocator
// no dependencies; imported by free_list_slab_allocator

package fls_pkg;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_EMPTY       = 2'd1,
      ST_DISABLED    = 2'd2,
      ST_DOUBLE_FREE = 2'd3
   } status_type;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   localparam int SLAB_INDEX_W = 4;
   localparam int DATA_W       = 8;

endpackage

// ===== hw/rtl/fls_slot_table.sv =====
// fls_slot_table: per-slot memory of {in_use, next_link} with a fresh-region watermark
// slots at or above the watermark read as a freshly built list; no package dependency

module fls_slot_table #(
   parameter int SLAB_COUNT = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             clear,
   input  logic                             rd_en,
   input  logic [$clog2(SLAB_COUNT)-1:0]    rd_addr,
   input  logic [$clog2(SLAB_COUNT)-1:0]    addr,
   input  logic                             wr_en,
   input  logic                             wr_in_use,
   input  logic [$clog2(SLAB_COUNT+1)-1:0]  wr_link,
   output logic                             slot_in_use,
   output logic [$clog2(SLAB_COUNT+1)-1:0]  slot_link
);

   localparam int LINK_W = $clog2(SLAB_COUNT + 1);

   logic [LINK_W:0]   slot_mem [SLAB_COUNT];
   logic [LINK_W:0]   rd_data_ff;
   logic [LINK_W-1:0] wm_ff;
   logic [LINK_W-1:0] wm_in;
   logic [LINK_W-1:0] addr_link;
   logic              fresh;

   assign addr_link = LINK_W'(addr);
   assign fresh     = (addr_link >= wm_ff);

   // never-written slots: link to the next slot, not in use
   assign slot_in_use = !fresh && rd_data_ff[LINK_W];
   assign slot_link   = fresh ? (addr_link + LINK_W'(1)) : rd_data_ff[LINK_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[addr] <= {wr_in_use, wr_link};
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   always_comb begin
      wm_in = wm_ff;
      if (clear) begin
         wm_in = '0;
      end else if (wr_en && wr_in_use && fresh) begin
         wm_in = wm_ff + LINK_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wm_ff <= '0;
      end else begin
         wm_ff <= wm_in;
      end
   end

endmodule

// ===== hw/rtl/free_list_slab_allocator.sv =====
// Slab slot allocator on a last-in-first-out linked free list. Each accepted request
// first reads the slot entry from the slot memory, then updates head and writes the
// entry back; no new request is taken until the current one is through, and a stalled
// response holds it; a finished response waits in an output register while the next request is
// taken. Writing pool_enable 0 rebuilds the list at once through a fill watermark, so
// there is no clearing pass after reset or disable.
// Depends on fls_pkg and fls_slot_table.

module free_list_slab_allocator
   import fls_pkg::*;
#(
   parameter int SLAB_COUNT = 16
) (
   input  logic              clock,
   input  logic              reset,
   // pool_enable register
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data,
   // request
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // [3:0] slab_index, [7:4] zero
   input  logic              req_tuser,   // [0] command
   // response
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // [3:0] granted_index, [7:4] zero
   output logic [1:0]        rsp_tuser    // [1:0] status
);

   localparam int IDX_W  = $clog2(SLAB_COUNT);
   localparam int LINK_W = $clog2(SLAB_COUNT + 1);
   localparam int AW     = (IDX_W > SLAB_INDEX_W) ? IDX_W : SLAB_INDEX_W;

   state_type         state_ff, state_in;
   logic              enable_ff, enable_in;
   logic [LINK_W-1:0] head_ff, head_in;
   command_type       cmd_ff;
   logic              slot_bad_ff;
   logic [IDX_W-1:0]  addr_ff, rd_addr;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [SLAB_INDEX_W-1:0] rsp_grant_ff, rsp_grant_in;

   logic              req_fire, csr_fire, done, empty;
   logic [AW-1:0]     slot_ext, addr_ext;
   logic              slot_bad;
   logic              wr_en, wr_in_use;
   logic [LINK_W-1:0] wr_link;
   logic              slot_in_use;
   logic [LINK_W-1:0] slot_link;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_fire   = csr_valid && csr_ready;

   assign slot_ext = AW'(req_tdata[SLAB_INDEX_W-1:0]);
   assign slot_bad = (32'(req_tdata[SLAB_INDEX_W-1:0]) >= SLAB_COUNT);
   assign rd_addr  = (command_type'(req_tuser) == CMD_FREE) ? slot_ext[IDX_W-1:0]
                                                           : head_ff[IDX_W-1:0];
   assign addr_ext = AW'(addr_ff);
   assign empty    = (head_ff == LINK_W'(SLAB_COUNT));
   assign done     = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);

   fls_slot_table #(
      .SLAB_COUNT (SLAB_COUNT)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .clear       (csr_fire && !csr_data),
      .rd_en       (req_fire),
      .rd_addr     (rd_addr),
      .addr        (addr_ff),
      .wr_en       (wr_en),
      .wr_in_use   (wr_in_use),
      .wr_link     (wr_link),
      .slot_in_use (slot_in_use),
      .slot_link   (slot_link)
   );

   always_comb begin
      state_in      = state_ff;
      enable_in     = enable_ff;
      head_in       = head_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_grant_in  = rsp_grant_ff;
      wr_en         = 1'b0;
      wr_in_use     = (cmd_ff == CMD_ALLOC);
      wr_link       = (cmd_ff == CMD_ALLOC) ? slot_link : head_ff;

      if (csr_fire) begin
         enable_in = csr_data;
         if (!csr_data) begin
            head_in = '0;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (done) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_grant_in  = '0;
               if (!enable_ff) begin
                  rsp_status_in = ST_DISABLED;
               end else if (cmd_ff == CMD_ALLOC) begin
                  if (empty) begin
                     rsp_status_in = ST_EMPTY;
                  end else begin
                     rsp_status_in = ST_OK;
                     rsp_grant_in  = addr_ext[SLAB_INDEX_W-1:0];
                     head_in       = slot_link;
                     wr_en         = 1'b1;
                  end
               end else begin
                  if (slot_bad_ff || !slot_in_use) begin
                     rsp_status_in = ST_DOUBLE_FREE;
                  end else begin
                     rsp_status_in = ST_OK;
                     head_in       = LINK_W'(addr_ff);
                     wr_en         = 1'b1;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         enable_ff    <= 1'b0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff      <= command_type'(req_tuser);
         slot_bad_ff <= slot_bad;
         addr_ff     <= rd_addr;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(DATA_W - SLAB_INDEX_W){1'b0}}, rsp_grant_ff};
   assign rsp_tuser  = rsp_status_ff;

`ifndef NO_ASSERTIONS
   // head is a slot or the null link
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LINK_W'(SLAB_COUNT))
      else $error("head beyond null link");

   // only a granted allocate carries a nonzero index
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> (rsp_tdata == '0))
      else $error("nonzero index on failed request");

   // one request in flight: no transfer in the cycle after one is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request taken while busy");

   // a refused pool leaves head at slot 0
   a_disabled_head: assert property (@(posedge clock) disable iff (reset)
      !enable_ff && !$past(enable_ff) |-> (head_ff == '0))
      else $error("head moved while pool disabled");
`endif

endmodule
